// File: src/ppdf_pkg.sv
package ppdf_pkg;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int PAT_W    = 16;
  localparam int LEN_W    = 11;
  localparam int REG_IDX_W = 2;

  // largest limit the max_payload register can hold
  localparam int MAX_REG_LIMIT = (1 << LEN_W) - 1;

  // parameter defaults
  localparam int PRE_LEN_DEF     = 2;
  localparam int POST_LEN_DEF    = 2;
  localparam int MAX_PAYLOAD_DEF = 1024;

  // register reset values
  localparam logic [PAT_W-1:0] PRE_PAT_RST  = '0;
  localparam logic [PAT_W-1:0] POST_PAT_RST = '0;
  localparam logic [LEN_W-1:0] MAX_PAY_RST  = LEN_W'(64);

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PREAMBLE    = 2'd0,
    REG_POSTAMBLE   = 2'd1,
    REG_MAX_PAYLOAD = 2'd2
  } cfg_reg_t;

  // configuration write payload
  typedef struct packed {
    logic [REG_IDX_W-1:0] reg_index;
    logic [PAT_W-1:0]     wdata;
  } ppdf_cfg_t;

  // one received byte
  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
  } ppdf_in_t;

  // one result per received byte
  typedef struct packed {
    logic              stored;
    logic [LEN_W-1:0]  store_index;
    logic [BYTE_W-1:0] store_byte;
    logic              overflow;
    logic              frame_end;
    logic              frame_delivered;
    logic [LEN_W-1:0]  payload_length;
  } ppdf_out_t;

endpackage

// File: src/ppdf_cfg_if.sv
interface ppdf_cfg_if import ppdf_pkg::*;;
  logic      valid;
  logic      ready;
  ppdf_cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/ppdf_in_if.sv
interface ppdf_in_if import ppdf_pkg::*;;
  logic     valid;
  logic     ready;
  ppdf_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/ppdf_out_if.sv
interface ppdf_out_if import ppdf_pkg::*;;
  logic      valid;
  logic      ready;
  ppdf_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/ppdf_matcher.sv
module ppdf_matcher import ppdf_pkg::*; #(
  parameter int LEN = PRE_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [PAT_W-1:0]  pattern,
  output logic              hit
);

  localparam int PW = (LEN > 1) ? $clog2(LEN) : 1;

  logic [PW-1:0]     pos_r;
  logic [PW-1:0]     pos_nxt;
  logic [BYTE_W-1:0] expected;

  // pattern byte at the current position, zero past the second byte
  always_comb begin
    if (pos_r == '0) begin
      expected = pattern[BYTE_W-1:0];
    end else if (pos_r == PW'(1)) begin
      expected = pattern[2*BYTE_W-1:BYTE_W];
    end else begin
      expected = '0;
    end
  end

  // advance on a match, restart and recheck against the first byte otherwise
  always_comb begin
    hit     = 1'b0;
    pos_nxt = pos_r;
    if (rx_byte == expected) begin
      if ((32'(pos_r) + 32'd1) >= 32'(LEN)) begin
        hit     = 1'b1;
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + PW'(1);
      end
    end else if (rx_byte == pattern[BYTE_W-1:0]) begin
      pos_nxt = PW'((LEN > 1) ? 1 : 0);
    end else begin
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// File: src/preamble_postamble_deframer_unit.sv
// Byte deframer: each received byte runs through a preamble matcher and a
// postamble matcher. A full preamble opens a frame and the bytes that follow
// are reported with their store position, up to max_payload plus the
// postamble length; past that the frame is dropped with overflow. A full
// postamble reports frame_end with the payload length and whether a frame was
// open. Every byte yields exactly one result. One byte is taken per clock
// cycle, and the single result register lets a new byte in while the previous
// result is being transferred out, so throughput stays at one byte per cycle
// and each result is registered; only a stalled result output holds the input.
// Configuration writes are taken at any time (ready is always high) and take
// effect from the next byte.
module preamble_postamble_deframer_unit import ppdf_pkg::*; #(
  parameter int PRE_LEN     = PRE_LEN_DEF,
  parameter int POST_LEN    = POST_LEN_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ppdf_cfg_if.sink    cfg_ch,
  ppdf_in_if.sink     in_ch,
  ppdf_out_if.source  out_ch
);

  localparam int LIMIT_MAX = (MAX_PAYLOAD < MAX_REG_LIMIT) ? MAX_PAYLOAD : MAX_REG_LIMIT;
  localparam int CW_RAW    = $clog2(LIMIT_MAX + POST_LEN + 1);
  localparam int CNT_W     = (CW_RAW > LEN_W) ? CW_RAW : LEN_W;

  logic [PAT_W-1:0] pre_pat_r;
  logic [PAT_W-1:0] post_pat_r;
  logic [LEN_W-1:0] max_pay_r;

  logic             collecting_r;
  logic             collecting_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic             out_valid_r;
  ppdf_out_t        out_data_r;
  ppdf_out_t        out_data_nxt;

  logic             in_fire;
  logic             pre_hit;
  logic             post_hit;
  logic [LEN_W-1:0] limit;
  logic [CNT_W-1:0] capacity;
  logic             coll_a;
  logic [CNT_W-1:0] count_a;
  logic             coll_b;
  logic [CNT_W-1:0] count_b;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_pat_r  <= PRE_PAT_RST;
      post_pat_r <= POST_PAT_RST;
      max_pay_r  <= MAX_PAY_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.reg_index)
        REG_PREAMBLE:    pre_pat_r  <= cfg_ch.data.wdata;
        REG_POSTAMBLE:   post_pat_r <= cfg_ch.data.wdata;
        REG_MAX_PAYLOAD: max_pay_r  <= cfg_ch.data.wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // pattern matchers
  ppdf_matcher #(.LEN(PRE_LEN)) u_pre_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_fire),
    .rx_byte (in_ch.data.rx_byte),
    .pattern (pre_pat_r),
    .hit     (pre_hit)
  );

  ppdf_matcher #(.LEN(POST_LEN)) u_post_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_fire),
    .rx_byte (in_ch.data.rx_byte),
    .pattern (post_pat_r),
    .hit     (post_hit)
  );

  // store capacity: clamped limit plus room for the postamble
  assign limit    = (max_pay_r > LEN_W'(LIMIT_MAX)) ? LEN_W'(LIMIT_MAX) : max_pay_r;
  assign capacity = CNT_W'(limit) + CNT_W'(POST_LEN);

  // per-byte update: store, then preamble, then postamble
  always_comb begin
    out_data_nxt = '0;
    coll_a       = collecting_r;
    count_a      = count_r;

    if (collecting_r) begin
      if (count_r < capacity) begin
        out_data_nxt.stored      = 1'b1;
        out_data_nxt.store_index = count_r[LEN_W-1:0];
        out_data_nxt.store_byte  = in_ch.data.rx_byte;
        count_a                  = count_r + CNT_W'(1);
      end else begin
        coll_a                = 1'b0;
        out_data_nxt.overflow = 1'b1;
      end
    end

    coll_b  = pre_hit ? 1'b1 : coll_a;
    count_b = pre_hit ? '0 : count_a;

    collecting_nxt = coll_b;
    count_nxt      = count_b;
    if (post_hit) begin
      out_data_nxt.frame_end       = 1'b1;
      out_data_nxt.frame_delivered = coll_b;
      if (count_b > CNT_W'(POST_LEN)) begin
        out_data_nxt.payload_length = LEN_W'(count_b - CNT_W'(POST_LEN));
      end
      collecting_nxt = 1'b0;
      count_nxt      = '0;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      count_r      <= '0;
    end else if (in_fire) begin
      collecting_r <= collecting_nxt;
      count_r      <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: src/ppdf_checker.sv
module ppdf_checker import ppdf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input ppdf_out_t out_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // delivery is only reported at a frame end
  a_deliv_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_delivered |-> out_data.frame_end)
    else $error("frame_delivered without frame_end");

  // store fields are zero unless the byte was stored
  a_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.stored |->
      (out_data.store_index == '0) && (out_data.store_byte == '0))
    else $error("store fields set on a byte that was not stored");

  // a byte cannot be both stored and rejected for overflow
  a_store_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.stored && out_data.overflow))
    else $error("stored and overflow together");

  // payload length only at frame end
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_end |-> out_data.payload_length == '0)
    else $error("payload_length outside frame end");

endmodule

bind preamble_postamble_deframer_unit ppdf_checker u_ppdf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// File: tb/tb_preamble_postamble_deframer_unit.sv
`timescale 1ns / 100ps

module tb_preamble_postamble_deframer_unit import ppdf_pkg::*;;

  logic clk;
  logic rst_n;

  ppdf_cfg_if cfg_bus();
  ppdf_in_if  rx_bus();
  ppdf_out_if res_bus();

  preamble_postamble_deframer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_bus),
    .in_ch  (rx_bus),
    .out_ch (res_bus)
  );

  // directed script rows
  typedef enum {ROW_CFG, ROW_BYTE, ROW_BYTE_KNOWN} row_kind_t;
  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    reg_idx;
    logic [15:0] value;
    ppdf_out_t   known;
  } script_row_t;

  script_row_t script[$];

  // deframer shadow state and register copies
  logic [PAT_W-1:0] pre_pat;
  logic [PAT_W-1:0] post_pat;
  logic [LEN_W-1:0] max_pay;
  int               pre_pos;
  int               post_pos;
  bit               collecting;
  int               byte_count;

  ppdf_out_t expected_q[$];
  int        mismatches;
  int        results_seen;
  int        bytes_sent;
  bit        no_gaps;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  initial begin
    #(6_000_000);
    $display("tb_preamble_postamble_deframer_unit: errors");
    $finish;
  end

  function automatic ppdf_out_t make_result(logic st, logic [LEN_W-1:0] idx,
                                            logic [BYTE_W-1:0] sb, logic ovf,
                                            logic fend, logic deliv,
                                            logic [LEN_W-1:0] plen);
    ppdf_out_t r;
    r.stored          = st;
    r.store_index     = idx;
    r.store_byte      = sb;
    r.overflow        = ovf;
    r.frame_end       = fend;
    r.frame_delivered = deliv;
    r.payload_length  = plen;
    return r;
  endfunction

  // pattern bytes past the second read as zero
  function automatic logic [7:0] pattern_at(logic [PAT_W-1:0] pat, int pos);
    if (pos >= 2) return 8'h00;
    return pat[8*pos +: 8];
  endfunction

  // one matcher step, restart on mismatch with a recheck of the first byte
  function automatic bit match_byte(inout int pos, input logic [PAT_W-1:0] pat,
                                    input int len, input logic [7:0] b);
    if (pos >= len) pos = 0;
    if (b == pattern_at(pat, pos)) begin
      if (pos + 1 >= len) begin
        pos = 0;
        return 1'b1;
      end
      pos++;
    end else begin
      pos = 0;
      if (b == pattern_at(pat, 0)) pos = (len > 1) ? 1 : 0;
    end
    return 1'b0;
  endfunction

  // store, preamble, then postamble, in that order
  function automatic ppdf_out_t deframe_byte(logic [7:0] b);
    int         capacity;
    int         plen;
    int         idx;
    logic       st;
    logic [7:0] sb;
    logic       ovf;
    logic       fend;
    logic       deliv;
    st = 1'b0; idx = 0; sb = 8'h00; ovf = 1'b0;
    fend = 1'b0; deliv = 1'b0; plen = 0;
    capacity = ((int'(max_pay) > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(max_pay))
               + POST_LEN_DEF;
    if (collecting) begin
      if (byte_count < capacity) begin
        st  = 1'b1;
        idx = byte_count;
        sb  = b;
        byte_count++;
      end else begin
        collecting = 1'b0;
        ovf        = 1'b1;
      end
    end
    if (match_byte(pre_pos, pre_pat, PRE_LEN_DEF, b)) begin
      collecting = 1'b1;
      byte_count = 0;
    end
    if (match_byte(post_pos, post_pat, POST_LEN_DEF, b)) begin
      fend       = 1'b1;
      plen       = (byte_count > POST_LEN_DEF) ? byte_count - POST_LEN_DEF : 0;
      deliv      = collecting;
      collecting = 1'b0;
      byte_count = 0;
    end
    return make_result(st, LEN_W'(idx), sb, ovf, fend, deliv, LEN_W'(plen));
  endfunction

  function automatic int draw_wait();
    if (no_gaps) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [15:0] pick_pattern();
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {r, r};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // payload byte, sometimes a pattern byte to stir the matchers
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return pre_pat[7:0];
      1: return post_pat[7:0];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_cfg(cfg_reg_t idx, logic [15:0] val);
    script_row_t row;
    row.kind = ROW_CFG; row.reg_idx = idx; row.value = val; row.known = '0;
    script.push_back(row);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    script_row_t row;
    row.kind = ROW_BYTE; row.reg_idx = REG_PREAMBLE; row.value = {8'h00, b};
    row.known = '0;
    script.push_back(row);
  endfunction

  function automatic void add_known(logic [7:0] b, ppdf_out_t known);
    script_row_t row;
    row.kind = ROW_BYTE_KNOWN; row.reg_idx = REG_PREAMBLE; row.value = {8'h00, b};
    row.known = known;
    script.push_back(row);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(ppdf_out_t got);
    ppdf_out_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      report_mismatch("transfer with nothing pending", 32'(got), 0);
      return;
    end
    want = expected_q.pop_front();
    if (got.stored !== want.stored)
      report_mismatch("stored", 32'(got.stored), 32'(want.stored));
    if (got.store_index !== want.store_index)
      report_mismatch("store_index", 32'(got.store_index), 32'(want.store_index));
    if (got.store_byte !== want.store_byte)
      report_mismatch("store_byte", 32'(got.store_byte), 32'(want.store_byte));
    if (got.overflow !== want.overflow)
      report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
    if (got.frame_end !== want.frame_end)
      report_mismatch("frame_end", 32'(got.frame_end), 32'(want.frame_end));
    if (got.frame_delivered !== want.frame_delivered)
      report_mismatch("frame_delivered", 32'(got.frame_delivered),
                      32'(want.frame_delivered));
    if (got.payload_length !== want.payload_length)
      report_mismatch("payload_length", 32'(got.payload_length),
                      32'(want.payload_length));
  endtask

  // one byte transfer; the expectation is taken when the byte is accepted
  task automatic send_byte(logic [7:0] b, bit known_given, ppdf_out_t known);
    int        gap;
    ppdf_out_t predicted;
    gap = draw_wait();
    if (gap > 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_bus.valid        <= 1'b1;
    rx_bus.data.rx_byte <= b;
    do @(posedge clk); while (rx_bus.ready !== 1'b1);
    predicted = deframe_byte(b);
    expected_q.push_back(known_given ? known : predicted);
    bytes_sent++;
    @(negedge clk);
  endtask

  // drain all pending results, then let the pipeline settle
  task automatic wait_idle();
    rx_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_bus.valid          <= 1'b1;
    cfg_bus.data.reg_index <= idx;
    cfg_bus.data.wdata     <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_PREAMBLE:    pre_pat = val;
      REG_POSTAMBLE:   post_pat = val;
      REG_MAX_PAYLOAD: max_pay = val[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  // mostly clean frames, some broken ones, some line noise
  task automatic send_frame();
    int kind;
    int len;
    int cap;
    int lim;
    cap  = ((int'(max_pay) > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(max_pay))
           + POST_LEN_DEF;
    lim  = (cap < 24) ? cap : 24;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      len = $urandom_range(0, lim + 2);
      send_byte(pre_pat[7:0], 1'b0, '0);
      send_byte(pre_pat[15:8], 1'b0, '0);
      repeat (len) send_byte(pick_byte(), 1'b0, '0);
      send_byte(post_pat[7:0], 1'b0, '0);
      send_byte(post_pat[15:8], 1'b0, '0);
    end else if (kind < 9) begin
      send_byte(pre_pat[7:0], 1'b0, '0);
      if ($urandom_range(0, 1) == 1) send_byte(pre_pat[15:8], 1'b0, '0);
      repeat ($urandom_range(0, 4)) send_byte(pick_byte(), 1'b0, '0);
      send_byte(post_pat[7:0], 1'b0, '0);
      send_byte(pick_byte(), 1'b0, '0);
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      if ($urandom_range(0, 1) == 1) begin
        send_byte(post_pat[7:0], 1'b0, '0);
        send_byte(post_pat[15:8], 1'b0, '0);
      end
    end
  endtask

  // result side with random stalls
  initial begin
    int stall;
    res_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (res_bus.valid !== 1'b1);
      check_result(res_bus.data);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    logic [15:0] pa;
    logic [15:0] pb;
    logic [15:0] mp;
    int          target;
    rst_n        = 1'b0;
    rx_bus.valid = 1'b0;
    rx_bus.data  = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data  = '0;
    pre_pat = PRE_PAT_RST; post_pat = POST_PAT_RST; max_pay = MAX_PAY_RST;
    pre_pos = 0; post_pos = 0; collecting = 1'b0; byte_count = 0;
    mismatches = 0; results_seen = 0; bytes_sent = 0; no_gaps = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // after reset both patterns are zero: second zero byte opens and closes a frame
    add_known(8'h00, make_result(1'b0, 11'd0, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0));
    add_known(8'h00, make_result(1'b0, 11'd0, 8'h00, 1'b0, 1'b1, 1'b1, 11'd0));
    add_known(8'hFF, make_result(1'b0, 11'd0, 8'h00, 1'b0, 1'b0, 1'b0, 11'd0));
    add_cfg(REG_PREAMBLE, 16'hA55A);
    add_cfg(REG_POSTAMBLE, 16'h0A0D);
    add_cfg(REG_MAX_PAYLOAD, 16'd2);
    // clean frame filling the store exactly
    add_byte(8'h5A); add_byte(8'hA5); add_byte(8'h11); add_byte(8'h22);
    add_byte(8'h0D); add_byte(8'h0A);
    // one byte past capacity drops the frame
    add_byte(8'h5A); add_byte(8'hA5);
    add_byte(8'h01); add_byte(8'h02); add_byte(8'h03); add_byte(8'h04);
    add_known(8'h05, make_result(1'b0, 11'd0, 8'h00, 1'b1, 1'b0, 1'b0, 11'd0));
    add_byte(8'h0D); add_byte(8'h0A);
    // postamble with no open frame
    add_byte(8'h0D);
    add_known(8'h0A, make_result(1'b0, 11'd0, 8'h00, 1'b0, 1'b1, 1'b0, 11'd0));
    // repeated first preamble byte, then an empty payload
    add_byte(8'h5A); add_byte(8'h5A); add_byte(8'hA5);
    add_byte(8'h0D); add_byte(8'h0A);

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_CFG: begin
          wait_idle();
          program_reg(script[i].reg_idx, script[i].value);
        end
        ROW_BYTE:       send_byte(script[i].value[7:0], 1'b0, '0);
        ROW_BYTE_KNOWN: send_byte(script[i].value[7:0], 1'b1, script[i].known);
        default: ;
      endcase
    end

    // random phases, each with fresh settings written while idle
    target = 950;
    while (bytes_sent < target) begin
      wait_idle();
      pa = pick_pattern();
      pb = ($urandom_range(0, 5) == 0) ? pa : pick_pattern();
      case ($urandom_range(0, 7))
        0: mp = 16'd0;
        1: mp = 16'd1;
        2: mp = 16'd2047;
        3: mp = 16'd1024;
        4: mp = 16'd1025;
        default: mp = 16'($urandom_range(0, 30));
      endcase
      program_reg(REG_PREAMBLE, pa);
      program_reg(REG_POSTAMBLE, pb);
      program_reg(REG_MAX_PAYLOAD, mp);
      no_gaps = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(3, 8)) send_frame();
    end
    no_gaps = 1'b0;

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_preamble_postamble_deframer_unit: clean");
    end else begin
      $display("tb_preamble_postamble_deframer_unit: errors");
    end
    $finish;
  end

endmodule

// File: preamble_postamble_deframer_unit.f
src/ppdf_pkg.sv
src/ppdf_cfg_if.sv
src/ppdf_in_if.sv
src/ppdf_out_if.sv
src/ppdf_matcher.sv
src/preamble_postamble_deframer_unit.sv
src/ppdf_checker.sv
tb/tb_preamble_postamble_deframer_unit.sv
